### design/lptp_pkg.sv
// shared types and constants for the length-prefixed tree parser
// no dependencies; imported by length_prefixed_tree_parser and its testbench
`default_nettype none
package lptp_pkg;

  localparam int LEN_BITS   = 32;
  localparam int INDEX_BITS = 16;
  localparam int COUNT_BITS = INDEX_BITS + 1;
  localparam int CHAIN_BITS = INDEX_BITS + 1;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 136;
  localparam int DEF_MAX_DEPTH = 16;
  localparam logic [15:0] SLOTS_RESET = 16'hFFFF;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LBRC = 8'h7B;
  localparam logic [7:0] CH_RBRC = 8'h7D;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_RBRK = 8'h5D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN_FIRST, PH_LEN_MORE, PH_SKIP, PH_EXPECT_GT, PH_CLOSE
  } phase_t;

  typedef enum logic [1:0] {
    MODE_DICT_KEY, MODE_DICT_VAL, MODE_ARRAY
  } mode_t;

  typedef enum logic [1:0] {
    KIND_RECORD, KIND_DONE, KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ETYPE_DICT, ETYPE_ARRAY, ETYPE_RAW
  } etype_t;

  typedef enum logic {
    REQ_START, REQ_BYTE
  } req_t;

  // one container frame on the nesting stack
  typedef struct packed {
    logic [LEN_BITS-1:0]   end_pos;
    mode_t                 mode;
    logic [INDEX_BITS-1:0] owner;
    logic [CHAIN_BITS-1:0] prev_key;
    logic [CHAIN_BITS-1:0] prev_val;
  } frame_t;

endpackage
`default_nettype wire

### design/length_prefixed_tree_parser.sv
// length-prefixed tree parser: one request per cycle unless stalled, one result register
// depends on lptp_pkg
`default_nettype none
// Takes a start request with the document length, then the document one byte per
// request, and emits one record per element (on its type byte), then a done
// result with the element count, or an error. For every request, the byte, the
// scalar parse state and the top stack frame (held in a cache register) feed a
// short block of logic that loads the result register, so a new request is taken
// every cycle while the result register is free or being taken. Frames below the
// top sit in a MAX_DEPTH-entry register array with one write port (push) and one
// read port (pop). No clearing pass after reset.
module length_prefixed_tree_parser
  import lptp_pkg::*;
#(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [15:0]              cfg_data,      // part_slots
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,      // total_len[31:0], data_byte[39:32]
  input  wire logic                     in_tuser,      // req_type
  input  wire logic                     in_tlast,      // last_byte
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // elem_index[15:0], elem_type[17:16], elem_len[49:18], content_offset[81:50],
  // parent_index[97:82], has_parent[98], prev_index[114:99], has_prev[115],
  // is_key[116], stored[117], elem_count[134:118], zero pad[135]
  output logic [OUT_DATA_BITS-1:0]      out_tdata,
  output logic [1:0]                    out_tuser      // result_kind
);

  localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SPW = $clog2(MAX_DEPTH + 1);
  localparam logic [LEN_BITS-1:0] LEN_MASK = '1;

  // state
  logic [LEN_BITS-1:0]   pos_r, pos_nxt;
  logic [LEN_BITS-1:0]   doc_len_r, doc_len_nxt;
  logic [LEN_BITS-1:0]   accum_r, accum_nxt;
  logic [LEN_BITS-1:0]   skip_r, skip_nxt;
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [CHAIN_BITS-1:0] top_prev_r, top_prev_nxt;
  frame_t                tos_r, tos_nxt;
  frame_t                stack_r [MAX_DEPTH];
  logic [15:0]           slots_r;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;
  logic [1:0]               out_kind_r;
  kind_t                    kind_nxt;
  logic                     res_nxt;
  logic                     push_en;
  logic [IW-1:0]            push_idx;
  logic [IW-1:0]            pop_idx;
  frame_t                   below;
  frame_t                   push_frame;

  logic in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // frame exposed by a pop
  assign pop_idx = IW'(sp_r - SPW'(2));
  assign push_idx = IW'(sp_r - SPW'(1));
  assign below   = stack_r[pop_idx];

  // request decode and parse step
  always_comb begin
    logic [LEN_BITS-1:0]   din_len;
    logic [7:0]            din;
    logic                  is_digit;
    logic [3:0]            dval;
    logic [LEN_BITS+3:0]   mul10;
    logic [LEN_BITS:0]     end_sum;
    logic [LEN_BITS-1:0]   pos_inc;
    logic                  inside_c;
    logic                  key;
    logic                  err;
    logic                  done;
    logic                  rec;
    etype_t                etype;
    logic                  etype_ok;
    logic [CHAIN_BITS-1:0] prev;
    logic [INDEX_BITS-1:0] idx;
    frame_t                upd;
    frame_t                top_after;
    logic [SPW-1:0]        sp_dec;

    din_len  = in_tdata[LEN_BITS-1:0];
    din      = in_tdata[LEN_BITS+7:LEN_BITS];
    is_digit = din inside {[CH_0:CH_9]};
    dval     = 4'(din - CH_0);
    mul10    = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + (LEN_BITS+4)'(dval);
    pos_inc  = pos_r + LEN_BITS'(1);
    end_sum  = {1'b0, accum_r} + {1'b0, pos_inc};
    inside_c = sp_r != '0;
    key      = inside_c && (tos_r.mode == MODE_DICT_KEY);
    idx      = count_r[INDEX_BITS-1:0];
    prev     = !inside_c ? top_prev_r : (key ? tos_r.prev_key : tos_r.prev_val);
    etype    = ETYPE_RAW;
    etype_ok = 1'b1;
    case (din)
      CH_LBRC: etype = ETYPE_DICT;
      CH_LBRK: etype = ETYPE_ARRAY;
      CH_LT:   etype = ETYPE_RAW;
      default: etype_ok = 1'b0;
    endcase
    upd       = tos_r;
    top_after = below;
    sp_dec    = sp_r - SPW'(1);

    pos_nxt      = pos_r;
    doc_len_nxt  = doc_len_r;
    accum_nxt    = accum_r;
    skip_nxt     = skip_r;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    sp_nxt       = sp_r;
    top_prev_nxt = top_prev_r;
    tos_nxt      = tos_r;
    push_en      = 1'b0;
    err  = 1'b0;
    done = 1'b0;
    rec  = 1'b0;

    if (in_acc) begin
      if (in_tuser == REQ_START) begin
        // start request: new document
        doc_len_nxt  = din_len;
        pos_nxt      = '0;
        accum_nxt    = '0;
        skip_nxt     = '0;
        count_nxt    = '0;
        sp_nxt       = '0;
        top_prev_nxt = '0;
        if (din_len == '0) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_LEN_FIRST;
        end
      end else if (phase_r != PH_IDLE) begin
        if (pos_r == LEN_MASK) begin
          err = 1'b1;
        end else begin
          pos_nxt = pos_inc;
          case (phase_r)
            PH_LEN_FIRST: begin
              if (!is_digit) begin
                err = 1'b1;
              end else begin
                accum_nxt = LEN_BITS'(dval);
                phase_nxt = PH_LEN_MORE;
              end
            end
            PH_LEN_MORE: begin
              if (is_digit) begin
                if (|mul10[LEN_BITS+3:LEN_BITS]) begin
                  err = 1'b1;
                end else begin
                  accum_nxt = mul10[LEN_BITS-1:0];
                end
              end else if (!etype_ok || (key && etype != ETYPE_RAW) || count_r[INDEX_BITS]
                           || end_sum[LEN_BITS]
                           || (etype != ETYPE_RAW && sp_r >= SPW'(MAX_DEPTH))) begin
                err = 1'b1;
              end else begin
                // element record on its type byte
                rec       = 1'b1;
                count_nxt = count_r + COUNT_BITS'(1);
                if (!inside_c) begin
                  top_prev_nxt = {1'b1, idx};
                end else begin
                  if (key) upd.prev_key = {1'b1, idx};
                  else     upd.prev_val = {1'b1, idx};
                  if (tos_r.mode != MODE_ARRAY) begin
                    upd.mode = key ? MODE_DICT_VAL : MODE_DICT_KEY;
                  end
                  tos_nxt = upd;
                end
                if (etype == ETYPE_RAW) begin
                  skip_nxt  = accum_r;
                  phase_nxt = (accum_r != '0) ? PH_SKIP : PH_EXPECT_GT;
                end else begin
                  push_en          = inside_c;
                  tos_nxt.end_pos  = end_sum[LEN_BITS-1:0];
                  tos_nxt.mode     = (etype == ETYPE_DICT) ? MODE_DICT_KEY : MODE_ARRAY;
                  tos_nxt.owner    = idx;
                  tos_nxt.prev_key = '0;
                  tos_nxt.prev_val = '0;
                  sp_nxt           = sp_r + SPW'(1);
                  phase_nxt        = (accum_r != '0) ? PH_LEN_FIRST : PH_CLOSE;
                end
              end
            end
            PH_SKIP: begin
              skip_nxt = skip_r - LEN_BITS'(1);
              if (skip_nxt == '0) phase_nxt = PH_EXPECT_GT;
            end
            PH_EXPECT_GT: begin
              if (din != CH_GT) begin
                err = 1'b1;
              end else if (!inside_c) begin
                if (pos_inc < doc_len_r) phase_nxt = PH_LEN_FIRST;
                else done = 1'b1;
              end else if (tos_r.mode == MODE_DICT_VAL || pos_inc < tos_r.end_pos) begin
                phase_nxt = PH_LEN_FIRST;
              end else begin
                phase_nxt = PH_CLOSE;
              end
            end
            PH_CLOSE: begin
              if (!inside_c ||
                  din != ((tos_r.mode == MODE_ARRAY) ? CH_RBRK : CH_RBRC)) begin
                err = 1'b1;
              end else begin
                // pop, exposing the frame below
                sp_nxt  = sp_dec;
                tos_nxt = top_after;
                if (sp_dec == '0) begin
                  if (pos_inc < doc_len_r) phase_nxt = PH_LEN_FIRST;
                  else done = 1'b1;
                end else if (top_after.mode == MODE_DICT_VAL ||
                             pos_inc < top_after.end_pos) begin
                  phase_nxt = PH_LEN_FIRST;
                end else begin
                  phase_nxt = PH_CLOSE;
                end
              end
            end
            default: err = 1'b1;
          endcase
          // source ran out before the document did
          if (!err && !done && in_tlast) err = 1'b1;
        end
      end
    end
    if (err || done) phase_nxt = PH_IDLE;
    if (err) push_en = 1'b0;
    // frame saved on a push is the updated parent
    push_frame = upd;

    // result assembly
    res_nxt      = err || done || rec;
    kind_nxt     = err ? KIND_ERROR : (done ? KIND_DONE : KIND_RECORD);
    out_data_nxt = '0;
    if (done && !err) begin
      out_data_nxt[134:118] = count_nxt;
    end else if (rec && !err) begin
      out_data_nxt[15:0]   = idx;
      out_data_nxt[17:16]  = etype;
      out_data_nxt[49:18]  = accum_r;
      out_data_nxt[81:50]  = pos_inc;
      out_data_nxt[97:82]  = inside_c ? tos_r.owner : '0;
      out_data_nxt[98]     = inside_c;
      out_data_nxt[114:99] = prev[INDEX_BITS] ? prev[INDEX_BITS-1:0] : '0;
      out_data_nxt[115]    = prev[INDEX_BITS];
      out_data_nxt[116]    = key;
      out_data_nxt[117]    = idx < slots_r;
    end
    if (err) begin
      count_nxt    = count_r;
      sp_nxt       = sp_r;
      tos_nxt      = tos_r;
      top_prev_nxt = top_prev_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      doc_len_r   <= '0;
      accum_r     <= '0;
      skip_r      <= '0;
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      sp_r        <= '0;
      top_prev_r  <= '0;
      slots_r     <= SLOTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      doc_len_r  <= doc_len_nxt;
      accum_r    <= accum_nxt;
      skip_r     <= skip_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      sp_r       <= sp_nxt;
      top_prev_r <= top_prev_nxt;
      if (cfg_valid && cfg_ready) slots_r <= cfg_data;
      if (in_acc && res_nxt) out_valid_r <= 1'b1;
      else if (out_tready)   out_valid_r <= 1'b0;
    end
  end

  // payload: result register, top frame cache and stack array
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (in_acc && res_nxt) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= kind_nxt;
    end
    if (push_en) stack_r[push_idx] <= push_frame;
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(MAX_DEPTH)) else $error("stack pointer beyond depth");
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_nxt && kind_nxt == KIND_ERROR) |=> phase_r == PH_IDLE)
    else $error("parser not idle after error");
  a_rec_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_RECORD) |->
      count_r > COUNT_BITS'(out_data_r[15:0]))
    else $error("record index not below element count");
`endif

endmodule
`default_nettype wire

### test/length_prefixed_tree_parser_test.sv
// testbench for length_prefixed_tree_parser: directed and random stream stimulus, built-in predictor
// depends on lptp_pkg and length_prefixed_tree_parser
`timescale 1ns / 1ps
module length_prefixed_tree_parser_test;
  import lptp_pkg::*;

  localparam int DEPTH = DEF_MAX_DEPTH;
  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        is_byte;
    logic [31:0] total;
    logic [7:0]  data;
    logic        last;
  } request_t;

  typedef struct packed {
    kind_t                 kind;
    logic [OUT_DATA_BITS-1:0] bits;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [1:0] out_tuser;

  length_prefixed_tree_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] slots;
  logic [31:0] pos, doc_len, len_acc, skip_left;
  phase_t      phase;
  logic [16:0] elem_cnt;
  int          sp;
  logic [31:0] f_end[DEPTH];
  mode_t       f_mode[DEPTH];
  logic [15:0] f_owner[DEPTH];
  logic [16:0] f_pkey[DEPTH];
  logic [16:0] f_pval[DEPTH];
  logic [16:0] top_prev;

  request_t      pending_q[$];
  parse_result_t expected_q[$];
  int            fail_count = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  function automatic void push_error();
    parse_result_t r;
    r.kind = KIND_ERROR;
    r.bits = '0;
    expected_q.push_back(r);
    phase = PH_IDLE;
  endfunction

  function automatic void push_done();
    parse_result_t r;
    r.kind = KIND_DONE;
    r.bits = '0;
    r.bits[134:118] = elem_cnt;
    expected_q.push_back(r);
    phase = PH_IDLE;
  endfunction

  // picks the next phase after an element; 1 when the document is complete
  function automatic bit next_after_elem();
    int f;
    if (sp == 0) begin
      if (pos < doc_len) begin
        phase = PH_LEN_FIRST;
        return 0;
      end
      phase = PH_IDLE;
      return 1;
    end
    f = sp - 1;
    if (f_mode[f] == MODE_DICT_VAL || pos < f_end[f]) phase = PH_LEN_FIRST;
    else phase = PH_CLOSE;
    return 0;
  endfunction

  // type byte: emits the element record and opens containers
  function automatic void on_type(input logic [7:0] c);
    etype_t et;
    bit key, nested, cont;
    int f;
    logic [16:0] prv;
    logic [15:0] idx;
    parse_result_t r;
    key = 0;
    nested = sp != 0;
    f = 0;
    if (c == CH_LBRC) et = ETYPE_DICT;
    else if (c == CH_LBRK) et = ETYPE_ARRAY;
    else if (c == CH_LT) et = ETYPE_RAW;
    else begin
      push_error();
      return;
    end
    cont = et != ETYPE_RAW;
    prv = top_prev;
    if (nested) begin
      f = sp - 1;
      key = f_mode[f] == MODE_DICT_KEY;
      prv = key ? f_pkey[f] : f_pval[f];
    end
    if ((key && cont) || elem_cnt[16] || {1'b0, len_acc} > {1'b0, LEN_MAX - pos} ||
        (cont && sp >= DEPTH)) begin
      push_error();
      return;
    end
    idx = elem_cnt[15:0];
    elem_cnt++;
    r.kind = KIND_RECORD;
    r.bits = '0;
    r.bits[15:0] = idx;
    r.bits[17:16] = et;
    r.bits[49:18] = len_acc;
    r.bits[81:50] = pos;
    r.bits[97:82] = nested ? f_owner[f] : 16'd0;
    r.bits[98] = nested;
    r.bits[114:99] = prv[16] ? prv[15:0] : 16'd0;
    r.bits[115] = prv[16];
    r.bits[116] = key;
    r.bits[117] = idx < slots;
    expected_q.push_back(r);
    if (!nested) top_prev = {1'b1, idx};
    else if (key) f_pkey[f] = {1'b1, idx};
    else f_pval[f] = {1'b1, idx};
    if (nested && f_mode[f] != MODE_ARRAY) f_mode[f] = key ? MODE_DICT_VAL : MODE_DICT_KEY;
    if (!cont) begin
      skip_left = len_acc;
      phase = len_acc != 0 ? PH_SKIP : PH_EXPECT_GT;
      return;
    end
    f_end[sp] = pos + len_acc;
    f_mode[sp] = et == ETYPE_DICT ? MODE_DICT_KEY : MODE_ARRAY;
    f_owner[sp] = idx;
    f_pkey[sp] = '0;
    f_pval[sp] = '0;
    sp++;
    void'(next_after_elem());
  endfunction

  // predicts the result of one accepted request
  function automatic void parse_request(input request_t q);
    logic [7:0] c;
    logic [31:0] d;
    int n0;
    c = q.data;
    n0 = expected_q.size();
    if (!q.is_byte) begin
      doc_len = q.total;
      pos = 0; len_acc = 0; skip_left = 0; elem_cnt = 0; sp = 0; top_prev = '0;
      if (doc_len == 0) push_done();
      else phase = PH_LEN_FIRST;
      return;
    end
    if (phase == PH_IDLE) return;
    if (pos == LEN_MAX) begin
      push_error();
      return;
    end
    pos++;
    case (phase)
      PH_LEN_FIRST: begin
        if (c < CH_0 || c > CH_9) begin
          push_error();
          return;
        end
        len_acc = 32'(c - CH_0);
        phase = PH_LEN_MORE;
      end
      PH_LEN_MORE: begin
        if (c >= CH_0 && c <= CH_9) begin
          d = 32'(c - CH_0);
          if (len_acc > (LEN_MAX - d) / 10) begin
            push_error();
            return;
          end
          len_acc = len_acc * 10 + d;
        end else begin
          on_type(c);
          if (phase == PH_IDLE) return;
        end
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == 0) phase = PH_EXPECT_GT;
      end
      PH_EXPECT_GT: begin
        if (c != CH_GT) begin
          push_error();
          return;
        end
        if (next_after_elem()) begin
          push_done();
          return;
        end
      end
      PH_CLOSE: begin
        if (sp == 0 || c != (f_mode[sp-1] == MODE_ARRAY ? CH_RBRK : CH_RBRC)) begin
          push_error();
          return;
        end
        sp--;
        if (next_after_elem()) begin
          push_done();
          return;
        end
      end
      default: begin
        push_error();
        return;
      end
    endcase
    // an early end replaces the record of this byte
    if (q.last && phase != PH_IDLE) begin
      if (expected_q.size() > n0) void'(expected_q.pop_back());
      push_error();
    end
  endfunction

  // request builders
  function automatic request_t start_req(input logic [31:0] n);
    request_t q;
    q.is_byte = 1'b0;
    q.total = n;
    q.data = 8'($urandom);
    q.last = 1'($urandom);
    return q;
  endfunction

  function automatic request_t byte_req(input logic [7:0] b, input bit last);
    request_t q;
    q.is_byte = 1'b1;
    q.total = $urandom;
    q.data = b;
    q.last = last;
    return q;
  endfunction

  task automatic add_text(input string s, input bit last_end);
    for (int i = 0; i < s.len(); i++)
      pending_q.push_back(byte_req(s[i], last_end && i == s.len() - 1));
  endtask

  task automatic add_doc(input string s);
    pending_q.push_back(start_req(s.len()));
    add_text(s, 1);
  endtask

  // random well-formed element, depth-limited; sometimes lengths are wrong on purpose
  function automatic string rand_elem(input int lvl, input bit as_key);
    string body, s;
    int n, k;
    k = as_key ? 2 : $urandom_range(0, 2);
    if (lvl > 16 || ($urandom_range(0, 3) == 0 && lvl > 3)) k = 2;
    if (k == 2) begin
      n = $urandom_range(0, 4);
      body = "";
      for (int i = 0; i < n; i++) body = {body, string'(8'($urandom))};
      return $sformatf("%0d<%s>", n, body);
    end
    n = $urandom_range(0, 3);
    body = "";
    for (int i = 0; i < n; i++) begin
      if (k == 0) body = {body, rand_elem(lvl + 1, 1), rand_elem(lvl + 1, 0)};
      else body = {body, rand_elem(lvl + 1, 0)};
    end
    n = body.len();
    if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n + 2);
    s = $sformatf("%0d%s%s%s", n, k == 0 ? "{" : "[", body, k == 0 ? "}" : "]");
    return s;
  endfunction

  // driver
  int gap_in = 0;
  bit in_busy = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_busy) begin
        // hold the request until it is accepted
      end else if (gap_in > 0) begin
        gap_in--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_q[0].is_byte;
        in_tdata <= {pending_q[0].data, pending_q[0].total};
        in_tlast <= pending_q[0].last;
        in_busy = 1'b1;
        gap_in = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // pop on acceptance, predict
  always @(posedge clk) begin
    request_t q;
    if (rst_n && in_tvalid && in_tready) begin
      q = pending_q.pop_front();
      in_busy = 1'b0;
      parse_request(q);
    end
  end

  // result stall
  int gap_out = 0;
  always @(negedge clk) begin
    if (gap_out > 0) begin
      gap_out--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      gap_out = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    parse_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d", out_tuser));
      end else begin
        e = expected_q.pop_front();
        if (out_tuser != e.kind)
          report($sformatf("kind %0d, want %0d", out_tuser, e.kind));
        else if (out_tdata != e.bits)
          report($sformatf("data %h, want %h", out_tdata, e.bits));
      end
    end
  end

  task automatic write_slots(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    slots = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    string s;
    logic [15:0] settings[4];
    settings = '{16'hFFFF, 16'd0, 16'd3, 16'd1000};
    slots = SLOTS_RESET;
    pos = 0; doc_len = 0; len_acc = 0; skip_left = 0; phase = PH_IDLE;
    elem_cnt = 0; sp = 0; top_prev = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty doc, idle bytes, each type, errors, nesting, restart
    pending_q.push_back(byte_req(8'hFF, 1));
    pending_q.push_back(start_req(0));
    add_doc("2<ab>");
    add_doc("4{1<k>0[]}");
    add_doc("3[0<>]");
    add_doc("x");
    add_doc("1{");
    add_doc("1[0<>}");
    add_doc("9999999999<");
    pending_q.push_back(start_req(LEN_MAX));
    add_text("4294967295<", 0);
    pending_q.push_back(start_req(10));
    add_text("0<>", 1);
    add_doc("0{0[]}");
    add_doc("0<x");
    pending_q.push_back(start_req(5));
    add_text("0", 0);
    add_doc({"0[0[0[0[0[0[0[0[0[0[0[0[0[0[0[0[0[", "]]]]]]]]]]]]]]]]]"});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_slots(settings[ph]);
      while (pending_q.size() < 350) begin
        s = "";
        for (int i = 0; i < $urandom_range(1, 3); i++) s = {s, rand_elem(0, 0)};
        if ($urandom_range(0, 7) == 0 && s.len() > 1) begin
          // corrupt one byte or truncate
          if ($urandom_range(0, 1)) s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
          else s = s.substr(0, $urandom_range(0, s.len() - 2));
        end
        pending_q.push_back(start_req($urandom_range(0, 5) == 0 ? $urandom : s.len()));
        add_text(s, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 15) == 0) pending_q.push_back(byte_req(8'($urandom), 1'($urandom)));
      end
      drain();
    end
    if (fail_count == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
